@@ sv/utt_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by every module of the block.
package utt_pkg;

    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [4:0]  SURR_TOP5    = 5'b11011;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [1:0]  OUT_DEPTH    = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_SURROGATE = 3'd4,
        ST_RANGE     = 3'd5
    } t_status;

    typedef struct packed {
        logic [15:0] code_unit;
        t_status     status;
        logic        run_last;
        logic        string_end;
    } t_result;

    typedef struct packed {
        logic [1:0]  rem;
        logic [20:0] pcp;
        logic        fault;
        logic        disc;
    } t_state;

    localparam t_state STATE_CLEAR = '{rem: 2'd0, pcp: 21'd0, fault: 1'b0, disc: 1'b0};

endpackage

@@ sv/utt_decode.sv @@
// Sequence decoder: holds the pending sequence state and forms up to two results per byte.
// Depends on utt_pkg.
module utt_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic [1:0]       o_cnt,
    output utt_pkg::t_result o_res0,
    output utt_pkg::t_result o_res1
);
    import utt_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [20:0] cont_pcp;
    logic [1:0]  cont_rem;
    logic        cont_fault;
    logic [20:0] fin_cp;
    logic [19:0] fin_v;
    logic [1:0]  fin_cnt;
    t_result     fin_r0;
    t_result     fin_r1;
    logic        fin_err;

    function automatic t_result f_err(input t_status st, input logic last);
        t_result r;
        r.code_unit  = 16'd0;
        r.status     = st;
        r.run_last   = 1'b1;
        r.string_end = last;
        return r;
    endfunction

    always_comb begin
        cont_pcp   = {r_state.pcp[14:0], i_byte[5:0]};
        cont_rem   = r_state.rem - 2'd1;
        cont_fault = r_state.fault | (i_byte[7:6] != 2'b10);
        fin_cp     = (r_state.rem == 2'd0) ? {13'd0, i_byte} : cont_pcp;
        fin_v      = fin_cp[19:0] - SUPP_BASE[19:0];
        fin_r1     = '{code_unit: SURR_LO_BASE | {6'd0, fin_v[9:0]}, status: ST_OK,
                       run_last: 1'b1, string_end: i_last};
        fin_err    = 1'b0;
        if (fin_cp < SUPP_BASE) begin
            if (fin_cp[15:11] == SURR_TOP5) begin
                fin_cnt = 2'd1;
                fin_r0  = f_err(ST_SURROGATE, i_last);
                fin_err = 1'b1;
            end else begin
                fin_cnt = 2'd1;
                fin_r0  = '{code_unit: fin_cp[15:0], status: ST_OK,
                            run_last: 1'b1, string_end: i_last};
            end
        end else if (fin_cp <= CP_MAX) begin
            fin_cnt = 2'd2;
            fin_r0  = '{code_unit: SURR_HI_BASE | {6'd0, fin_v[19:10]}, status: ST_OK,
                        run_last: 1'b0, string_end: i_last};
        end else begin
            fin_cnt = 2'd1;
            fin_r0  = f_err(ST_RANGE, i_last);
            fin_err = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cnt   = 2'd0;
        o_res0  = fin_r0;
        o_res1  = fin_r1;
        if (r_state.disc) begin
            if (i_last) begin
                n_state = STATE_CLEAR;
            end
        end else if (r_state.rem == 2'd0) begin
            case (i_byte) inside
                [8'h00:8'h7F]: begin
                    n_state = STATE_CLEAR;
                    o_cnt   = fin_cnt;
                end
                [8'hC0:8'hF7]: begin
                    if (i_last) begin
                        n_state      = STATE_CLEAR;
                        o_cnt        = 2'd1;
                        o_res0       = f_err(ST_TRUNCATED, i_last);
                    end else begin
                        n_state.fault = 1'b0;
                        n_state.disc  = 1'b0;
                        if (i_byte[5] == 1'b0) begin
                            n_state.rem = 2'd1;
                            n_state.pcp = {16'd0, i_byte[4:0]};
                        end else if (i_byte[4] == 1'b0) begin
                            n_state.rem = 2'd2;
                            n_state.pcp = {17'd0, i_byte[3:0]};
                        end else begin
                            n_state.rem = 2'd3;
                            n_state.pcp = {18'd0, i_byte[2:0]};
                        end
                    end
                end
                default: begin
                    n_state      = STATE_CLEAR;
                    n_state.disc = !i_last;
                    o_cnt        = 2'd1;
                    o_res0       = f_err(ST_BAD_LEAD, i_last);
                end
            endcase
        end else if (cont_rem != 2'd0) begin
            if (i_last) begin
                n_state = STATE_CLEAR;
                o_cnt   = 2'd1;
                o_res0  = f_err(ST_TRUNCATED, i_last);
            end else begin
                n_state.rem   = cont_rem;
                n_state.pcp   = cont_pcp;
                n_state.fault = cont_fault;
            end
        end else if (cont_fault) begin
            n_state      = STATE_CLEAR;
            n_state.disc = !i_last;
            o_cnt        = 2'd1;
            o_res0       = f_err(ST_BAD_CONT, i_last);
        end else begin
            n_state      = STATE_CLEAR;
            n_state.disc = fin_err & !i_last;
            o_cnt        = fin_cnt;
        end
        if (o_cnt == 2'd1 && fin_err == 1'b0 && o_res0.status == ST_OK) begin
            o_res0.run_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_disc_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.disc |-> o_cnt == 2'd0)
        else $error("result formed while dropping bytes");
    a_pair_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cnt == 2'd2 |-> o_res0.code_unit[15:10] == 6'b110110
                          && o_res1.code_unit[15:10] == 6'b110111 && !o_res0.run_last)
        else $error("malformed surrogate pair");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_last |=> r_state.rem == 2'd0 && !r_state.disc && !r_state.fault)
        else $error("state not cleared at string end");
`endif

endmodule

@@ sv/utt_outbuf.sv @@
// Two-slot result queue that drives the output channel and absorbs surrogate pairs.
// Depends on utt_pkg.
module utt_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  logic [1:0]       i_res_cnt,
    input  utt_pkg::t_result i_res0,
    input  utt_pkg::t_result i_res1,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_stall,
    output utt_pkg::t_result o_head
);
    import utt_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_slot [2];
    t_result    n_slot [2];
    logic       pop;
    logic       push;
    logic [1:0] base;
    logic [2:0] need;

    always_comb begin
        pop    = (r_cnt != 2'd0) && !i_stall;
        base   = r_cnt - {1'b0, pop};
        need   = {1'b0, base} + {1'b0, i_res_cnt};
        o_take = need <= {1'b0, OUT_DEPTH};
        push   = i_res_valid && o_take;
        n_slot = r_slot;
        if (pop) begin
            n_slot[0] = r_slot[1];
        end
        if (push && i_res_cnt != 2'd0) begin
            n_slot[base[0]] = i_res0;
            if (i_res_cnt == 2'd2) begin
                n_slot[1] = i_res1;
            end
        end
        n_cnt = push ? need[1:0] : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_head  = r_slot[0];

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OUT_DEPTH)
        else $error("result queue overfilled");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid && !o_valid |=> r_cnt == 2'd0)
        else $error("result queue filled without a transaction");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_head.status != ST_OK |-> o_head.code_unit == 16'd0 && o_head.run_last)
        else $error("error result carries a code unit");
`endif

endmodule

@@ sv/utf8_to_utf16_transcoder_top.sv @@
// UTF-8 to UTF-16 transcoder, top level: input register, decoder, result queue.
// Path: each byte is held in the input register, decoded combinationally, then registered in the queue.
// Throughput: one byte per cycle; the two-slot queue absorbs a surrogate pair, so the
// input stalls only when a stalled output leaves too little room for the next byte's results.
// Reset: synchronous, active low; clears sequence state and empties the queue.
// Depends on utt_pkg, utt_decode and utt_outbuf.
module utf8_to_utf16_transcoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_string_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic [2:0]  o_status,
    output logic        o_run_last,
    output logic        o_string_end
);
    import utt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       take;
    logic [1:0] res_cnt;
    t_result    res0;
    t_result    res1;
    t_result    head;

    assign o_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_byte_value;
            r_last <= i_string_last;
        end
    end

    utt_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (r_in_valid && take),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_cnt   (res_cnt),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    utt_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (r_in_valid),
        .i_res_cnt   (res_cnt),
        .i_res0      (res0),
        .i_res1      (res1),
        .o_take      (take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_head      (head)
    );

    assign o_code_unit  = head.code_unit;
    assign o_status     = head.status;
    assign o_run_last   = head.run_last;
    assign o_string_end = head.string_end;

endmodule

@@ tb/sv/utf8_to_utf16_transcoder_top_tb.sv @@
// Self-checking testbench for utf8_to_utf16_transcoder_top: drives UTF-8 strings
// with random gaps and stalls and checks each UTF-16 unit against a built-in decoder.
// Depends on utt_pkg and the transcoder RTL.
module utf8_to_utf16_transcoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utt_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       last;
        int         gap;
        logic       drain;
    } t_byte_txn;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_string_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_code_unit;
    logic [2:0]  o_status;
    logic        o_run_last;
    logic        o_string_end;

    t_byte_txn   byte_queue[$];
    t_result     pending_units[$];
    logic [7:0]  str_bytes[$];

    logic [1:0]  seq_left = 2'd0;
    logic [20:0] cp_acc = 21'd0;
    logic        cont_bad = 1'b0;
    logic        dropping = 1'b0;

    t_byte_txn   cur_txn;
    logic        have_cur = 1'b0;
    int          gap_left = 0;
    int          rx_wait = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        drain_next = 1'b0;
    logic        drain_marked = 1'b0;

    int          n_gen = 0;
    int          bytes_sent = 0;
    int          strings_sent = 0;
    int          units_seen = 0;
    int          error_units = 0;
    int          stall_seen = 0;
    int          errors = 0;

    utf8_to_utf16_transcoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_byte_value  (i_byte_value),
        .i_string_last (i_string_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_unit   (o_code_unit),
        .o_status      (o_status),
        .o_run_last    (o_run_last),
        .o_string_end  (o_string_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(input int phase);
        case (phase % 4)
            0: draw_wait = 0;
            1: draw_wait = $urandom_range(0, 15);
            2: draw_wait = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
            default: draw_wait = $urandom_range(0, 3);
        endcase
    endfunction

    task automatic push_unit(input logic [15:0] unit, input t_status st,
                             input logic rlast, input logic send);
        t_result r;
        r.code_unit  = unit;
        r.status     = st;
        r.run_last   = rlast;
        r.string_end = send;
        pending_units.insert(pending_units.size(), r);
    endtask

    task automatic append_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    task automatic clear_sequence();
        seq_left = 2'd0;
        cp_acc   = 21'd0;
        cont_bad = 1'b0;
        dropping = 1'b0;
    endtask

    task automatic report_error(input t_status st, input logic send);
        push_unit(16'h0000, st, 1'b1, send);
        clear_sequence();
        dropping = !send;
    endtask

    task automatic emit_code_point(input logic [20:0] cp, input logic send);
        logic [20:0] offs;
        offs = cp - SUPP_BASE;
        if (cp < SUPP_BASE) begin
            if (cp[15:11] == SURR_TOP5)
                report_error(ST_SURROGATE, send);
            else
                push_unit(cp[15:0], ST_OK, 1'b1, send);
        end else if (cp <= CP_MAX) begin
            push_unit(SURR_HI_BASE | {6'd0, offs[19:10]}, ST_OK, 1'b0, send);
            push_unit(SURR_LO_BASE | {6'd0, offs[9:0]}, ST_OK, 1'b1, send);
        end else begin
            report_error(ST_RANGE, send);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic send);
        logic [20:0] cp;
        logic        bad;
        if (dropping) begin
            if (send)
                clear_sequence();
        end else if (seq_left == 2'd0) begin
            if (b[7] == 1'b0) begin
                clear_sequence();
                emit_code_point({13'd0, b}, send);
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
                if (send) begin
                    report_error(ST_TRUNCATED, send);
                end else begin
                    cont_bad = 1'b0;
                    if (b[7:5] == 3'b110) begin
                        seq_left = 2'd1;
                        cp_acc   = {16'd0, b[4:0]};
                    end else if (b[7:4] == 4'b1110) begin
                        seq_left = 2'd2;
                        cp_acc   = {17'd0, b[3:0]};
                    end else begin
                        seq_left = 2'd3;
                        cp_acc   = {18'd0, b[2:0]};
                    end
                end
            end else begin
                report_error(ST_BAD_LEAD, send);
            end
        end else begin
            if (b[7:6] != 2'b10)
                cont_bad = 1'b1;
            cp_acc   = {cp_acc[14:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left != 2'd0) begin
                if (send)
                    report_error(ST_TRUNCATED, send);
            end else begin
                cp  = cp_acc;
                bad = cont_bad;
                clear_sequence();
                if (bad)
                    report_error(ST_BAD_CONT, send);
                else
                    emit_code_point(cp, send);
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] value, input logic last);
        t_byte_txn t;
        t.value    = value;
        t.last     = last;
        t.gap      = draw_wait(n_gen / 100);
        t.drain    = drain_next;
        drain_next = 1'b0;
        byte_queue.insert(byte_queue.size(), t);
        n_gen++;
    endtask

    task automatic queue_string();
        foreach (str_bytes[i])
            queue_byte(str_bytes[i], i == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    task automatic encode_char(input logic odd);
        logic [20:0] cp;
        int          nb;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            cp = 21'($urandom_range(0, 'h7F));
            nb = 1;
        end else if (sel < 5) begin
            cp = 21'($urandom_range('h80, 'h7FF));
            nb = 2;
        end else if (sel < 8) begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp[15:11] == SURR_TOP5)
                cp[13] = 1'b1;
            nb = 3;
        end else begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
            nb = 4;
        end
        if (nb < 4 && $urandom_range(0, 15) == 0)
            nb++;
        if (odd) begin
            case ($urandom_range(0, 3))
                0: begin
                    cp = 21'($urandom_range('h110000, 'h1FFFFF));
                    nb = 4;
                end
                1: begin
                    cp = 21'($urandom_range('hD800, 'hDFFF));
                    nb = 3;
                end
                default: ;
            endcase
        end
        case (nb)
            1: append_byte({1'b0, cp[6:0]});
            2: begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3: begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default: begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    always @(posedge i_clk) begin : byte_driver
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        logic       nxt_last;
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            i_byte_value  <= 8'h00;
            i_string_last <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            nxt_byte  = i_byte_value;
            nxt_last  = i_string_last;
            if (i_valid && o_stall)
                stall_seen++;
            if (i_valid && !o_stall) begin
                decode_byte(i_byte_value, i_string_last);
                bytes_sent++;
                if (i_string_last)
                    strings_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (!have_cur && byte_queue.size() > 0) begin
                    cur_txn  = byte_queue.pop_front();
                    have_cur = 1'b1;
                    gap_left = cur_txn.gap;
                end
                nxt_byte = 8'($urandom_range(0, 255));
                nxt_last = 1'($urandom_range(0, 1));
                if (have_cur) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (!(cur_txn.drain && pending_units.size() > 0)) begin
                        nxt_valid = 1'b1;
                        nxt_byte  = cur_txn.value;
                        nxt_last  = cur_txn.last;
                        have_cur  = 1'b0;
                    end
                end
            end
            i_valid       <= nxt_valid;
            i_byte_value  <= nxt_byte;
            i_string_last <= nxt_last;
        end
    end

    always @(posedge i_clk) begin : unit_monitor
        t_result want;
        logic    nxt_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                units_seen++;
                if (pending_units.size() == 0) begin
                    errors++;
                    $display("%0t: expected no unit, actual %h status %0d run_last %b end %b",
                             $time, o_code_unit, o_status, o_run_last, o_string_end);
                end else begin
                    want = pending_units.pop_front();
                    if (want.status != ST_OK)
                        error_units++;
                    if (o_code_unit !== want.code_unit || o_status !== want.status ||
                        o_run_last !== want.run_last || o_string_end !== want.string_end) begin
                        errors++;
                        $display("%0t: mismatch expected %h/%0d/%b/%b actual %h/%0d/%b/%b",
                                 $time, want.code_unit, want.status, want.run_last,
                                 want.string_end, o_code_unit, o_status, o_run_last,
                                 o_string_end);
                    end
                end
                rx_wait = draw_wait(units_seen / 128);
            end
            if (!hold_done && bytes_sent >= 400) begin
                hold_done = 1'b1;
                hold_left = 120;
            end
            nxt_stall = 1'b0;
            if (hold_left > 0) begin
                hold_left--;
                nxt_stall = 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                nxt_stall = 1'b1;
            end
            i_stall <= nxt_stall;
        end
    end

    initial begin : stimulus
        int kind;
        str_bytes = '{8'h00, 8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F};
        queue_string();
        str_bytes = '{8'hFF, 8'h80};
        queue_string();
        str_bytes = '{8'hE2, 8'h41, 8'hAC};
        queue_string();
        str_bytes = '{8'hF0, 8'h41};
        queue_string();
        str_bytes = '{8'hC3};
        queue_string();
        str_bytes = '{8'hED, 8'hA0, 8'h80};
        queue_string();
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        queue_string();

        while (n_gen < 1330) begin
            if (n_gen >= 900 && !drain_marked) begin
                drain_next   = 1'b1;
                drain_marked = 1'b1;
            end
            kind = $urandom_range(0, 19);
            if (kind >= 17) begin
                repeat ($urandom_range(1, 8))
                    append_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6))
                    encode_char(kind >= 12 && $urandom_range(0, 2) == 0);
                if (kind >= 12) begin
                    case ($urandom_range(0, 2))
                        0: str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
                               8'($urandom_range(0, 255));
                        1: if (str_bytes.size() > 1)
                               str_bytes = str_bytes[0:$-1];
                        default: str_bytes.insert($urandom_range(0, str_bytes.size() - 1),
                                                  8'($urandom_range('h80, 'hBF)));
                    endcase
                end
            end
            queue_string();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(byte_queue.size() == 0 && !have_cur && !i_valid &&
                 pending_units.size() == 0))
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d bytes in %0d strings; %0d units checked, %0d error reports.",
                 bytes_sent, strings_sent, units_seen, error_units);
        $display("Input held off on %0d cycles; %0d mismatches.", stall_seen, errors);
        if (errors == 0 && pending_units.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout after %0d bytes and %0d units.", bytes_sent, units_seen);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
